FILE: rtl/lnws_pkg.sv
`default_nettype none

package lnws_pkg;

	// Default depth of the address/data pair queue.
	localparam int unsigned QUEUE_PAIRS_DEF = 16;

	// Display address layout: set-address command bit, row bit, gap bit, column bits.
	localparam logic [7:0] PREV_ADDR_RESET = 8'hFF;
	localparam logic       ADDR_CMD_BIT    = 1'b1;
	localparam logic       ADDR_GAP_BIT    = 1'b0;

	// Action codes of an input request.
	localparam logic ACT_TICK  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	// Register select levels.
	localparam logic RS_CMD  = 1'b0;
	localparam logic RS_DATA = 1'b1;

	// Strobe sequence steps. Odd steps raise enable with a nibble, the even _END steps drop it.
	typedef enum logic [3:0] {
		SEQ_IDLE        = 4'd0,
		SEQ_ADDR_HI     = 4'd1,
		SEQ_ADDR_HI_END = 4'd2,
		SEQ_ADDR_LO     = 4'd3,
		SEQ_ADDR_LO_END = 4'd4,
		SEQ_DATA_HI     = 4'd5,
		SEQ_DATA_HI_END = 4'd6,
		SEQ_DATA_LO     = 4'd7,
		SEQ_DATA_LO_END = 4'd8
	} seq_step_t;

	// A classified request as it travels from the front to the back.
	typedef struct packed {
		logic       is_write;
		logic [7:0] addr;
		logic [7:0] code;
	} lnws_req_t;

endpackage

`default_nettype wire

FILE: rtl/lnws_front.sv
`default_nettype none

module lnws_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire logic              action,
	input  wire logic              row,
	input  wire logic [4:0]        column,
	input  wire logic [7:0]        char_code,
	output logic                   req_valid,
	input  wire logic              req_ready,
	output lnws_pkg::lnws_req_t    req
);
	import lnws_pkg::*;

	lnws_req_t  entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;
	lnws_req_t  cls;

	// Classify the incoming request and build the display address.
	always_comb begin
		cls.is_write = (action == ACT_WRITE);
		cls.addr     = {ADDR_CMD_BIT, row, ADDR_GAP_BIT, column};
		cls.code     = char_code;
	end

	assign item_ready = (cnt_q != 2'd2);
	assign push       = item_valid && item_ready;
	assign req_valid  = (cnt_q != 2'd0);
	assign pop        = req_valid && req_ready;
	assign req        = entry_q[rd_ptr_q];

	// Two-entry queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Queue payload storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/lnws_back.sv
`default_nettype none

module lnws_back #(
	parameter int unsigned QUEUE_PAIRS = lnws_pkg::QUEUE_PAIRS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire lnws_pkg::lnws_req_t req,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output logic [3:0]             lcd_nibble,
	output logic                   reg_select,
	output logic                   enable,
	output logic                   busy_res,
	output logic                   write_rejected
);
	import lnws_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_PAIRS);
	localparam int unsigned CNT_W = $clog2(QUEUE_PAIRS + 1);

	// Pair memory and the prefetched entry behind the head.
	logic [15:0]      pair_mem [QUEUE_PAIRS];
	logic [15:0]      next_pair_q;
	logic [15:0]      head_pair_q;

	seq_step_t        step_q,      step_d;
	logic [7:0]       prev_addr_q, prev_addr_d;
	logic [PTR_W-1:0] head_q,      head_d;
	logic [PTR_W-1:0] tail_q,      tail_d;
	logic [CNT_W-1:0] count_q,     count_d;
	logic [3:0]       nibble_q,    nibble_d;
	logic             rs_q,        rs_d;
	logic             en_q,        en_d;
	logic             busy_q,      busy_d;
	logic [15:0]      head_pair_d;
	logic             rejected_d;

	logic             go;
	logic             mem_we;
	logic [15:0]      mem_wdata;
	logic [PTR_W-1:0] rd_addr;
	logic [7:0]       head_addr;
	logic [7:0]       head_data;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(QUEUE_PAIRS - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	// A request is carried out when the result register is free or being drained.
	assign req_ready = !result_valid || result_ready;
	assign go        = req_valid && req_ready;
	assign rd_addr   = ptr_inc(head_q);
	assign head_addr = head_pair_q[15:8];
	assign head_data = head_pair_q[7:0];
	assign mem_wdata = {req.addr, req.code};

	// Next state of the queue and the strobe sequencer for one request.
	always_comb begin
		step_d      = step_q;
		prev_addr_d = prev_addr_q;
		head_d      = head_q;
		tail_d      = tail_q;
		count_d     = count_q;
		nibble_d    = nibble_q;
		rs_d        = rs_q;
		en_d        = en_q;
		busy_d      = busy_q;
		head_pair_d = head_pair_q;
		rejected_d  = 1'b0;
		mem_we      = 1'b0;
		if (go && req.is_write) begin
			if (count_q == CNT_W'(QUEUE_PAIRS)) begin
				rejected_d = 1'b1;
			end else begin
				mem_we  = 1'b1;
				tail_d  = ptr_inc(tail_q);
				count_d = count_q + CNT_W'(1);
				busy_d  = 1'b1;
				if (count_q == '0) begin
					head_pair_d = mem_wdata;
				end
			end
		end else if (go) begin
			unique case (step_q)
				SEQ_IDLE: begin
					if (count_q != '0) begin
						step_d      = (head_addr == prev_addr_q + 8'd1) ? SEQ_DATA_HI : SEQ_ADDR_HI;
						prev_addr_d = head_addr;
					end
				end
				SEQ_ADDR_HI: begin
					rs_d     = RS_CMD;
					nibble_d = head_addr[7:4];
					en_d     = 1'b1;
					step_d   = SEQ_ADDR_HI_END;
				end
				SEQ_ADDR_LO: begin
					rs_d     = RS_CMD;
					nibble_d = head_addr[3:0];
					en_d     = 1'b1;
					step_d   = SEQ_ADDR_LO_END;
				end
				SEQ_DATA_HI: begin
					rs_d     = RS_DATA;
					nibble_d = head_data[7:4];
					en_d     = 1'b1;
					step_d   = SEQ_DATA_HI_END;
				end
				SEQ_DATA_LO: begin
					rs_d     = RS_DATA;
					nibble_d = head_data[3:0];
					en_d     = 1'b1;
					step_d   = SEQ_DATA_LO_END;
				end
				SEQ_ADDR_HI_END: begin
					en_d   = 1'b0;
					step_d = SEQ_ADDR_LO;
				end
				SEQ_ADDR_LO_END: begin
					en_d   = 1'b0;
					step_d = SEQ_DATA_HI;
				end
				SEQ_DATA_HI_END: begin
					en_d   = 1'b0;
					step_d = SEQ_DATA_LO;
				end
				SEQ_DATA_LO_END: begin
					en_d = 1'b0;
					rs_d = RS_DATA;
					if (count_q != '0) begin
						count_d     = count_q - CNT_W'(1);
						head_d      = ptr_inc(head_q);
						head_pair_d = next_pair_q;
					end
					if (count_q <= CNT_W'(1)) begin
						busy_d = 1'b0;
					end
					step_d = SEQ_IDLE;
				end
				default: begin
					step_d = SEQ_IDLE;
				end
			endcase
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= SEQ_IDLE;
			prev_addr_q  <= PREV_ADDR_RESET;
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			nibble_q     <= 4'd0;
			rs_q         <= 1'b0;
			en_q         <= 1'b0;
			busy_q       <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			step_q      <= step_d;
			prev_addr_q <= prev_addr_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			count_q     <= count_d;
			nibble_q    <= nibble_d;
			rs_q        <= rs_d;
			en_q        <= en_d;
			busy_q      <= busy_d;
			if (go) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		head_pair_q <= head_pair_d;
		if (go) begin
			lcd_nibble     <= nibble_d;
			reg_select     <= rs_d;
			enable         <= en_d;
			busy_res       <= busy_d;
			write_rejected <= rejected_d;
		end
	end

	// Pair memory: write at the tail, read the entry behind the head with write bypass.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			pair_mem[tail_q] <= mem_wdata;
		end
		if (mem_we && (tail_q == rd_addr)) begin
			next_pair_q <= mem_wdata;
		end else begin
			next_pair_q <= pair_mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/lcd_nibble_write_sequencer_unit.sv
`default_nettype none

// Character LCD writer for the 4-bit interface. Each request is either a write
// (row, column, character code), which queues an address/data pair in a memory
// of QUEUE_PAIRS entries, or a tick, which moves the enable-strobe sequence one
// step and drives the nibble, register select and enable lines. Every request
// produces exactly one result carrying the line levels after it, the busy flag
// and a reject flag for writes dropped because the queue is full. The block
// takes one request per clock cycle while the result register is free or being
// drained; a request passes a two-entry front queue and then the state update
// in the back end, whose sequencer and queue update set that rate. The result
// is held in the result register until it is taken.
// No clearing pass runs after reset.
module lcd_nibble_write_sequencer_unit #(
	parameter int unsigned QUEUE_PAIRS = lnws_pkg::QUEUE_PAIRS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	output logic            item_ready,
	input  wire logic       action,
	input  wire logic       row,
	input  wire logic [4:0] column,
	input  wire logic [7:0] char_code,
	output logic            result_valid,
	input  wire logic       result_ready,
	output logic [3:0]      lcd_nibble,
	output logic            reg_select,
	output logic            enable,
	output logic            busy_res,
	output logic            write_rejected
);
	import lnws_pkg::*;

	logic      req_valid;
	logic      req_ready;
	lnws_req_t req;

	// Front end: accept and classify requests.
	lnws_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.action     (action),
		.row        (row),
		.column     (column),
		.char_code  (char_code),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req)
	);

	// Back end: pair queue, strobe sequencer and result register.
	lnws_back #(
		.QUEUE_PAIRS (QUEUE_PAIRS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.req            (req),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.lcd_nibble     (lcd_nibble),
		.reg_select     (reg_select),
		.enable         (enable),
		.busy_res       (busy_res),
		.write_rejected (write_rejected)
	);

endmodule

`default_nettype wire
